/* hw/rtl/rnabpm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnabpm_pkg
// Shared types and constants of the base-pair maximizer: widths, table codes
// and the sequencer state encoding.
// ----------------------------------------------------------------------------
package rnabpm_pkg;

	localparam int MAX_BASES   = 128;
	localparam int POS_W       = 8;
	localparam int IDX_W       = 7;
	localparam int SCORE_W     = 7;
	localparam int SPLIT_W     = 8;
	localparam int DIST_W      = 5;
	localparam int TAB_DEPTH   = MAX_BASES * MAX_BASES;
	localparam int STACK_DEPTH = MAX_BASES / 2;
	localparam int SP_W        = 7;

	localparam logic [SPLIT_W-1:0] SPLIT_SKIP = 8'h00;
	localparam logic [SPLIT_W-1:0] SPLIT_NONE = 8'hFF;

	typedef logic [POS_W-1:0]   pos_t;
	typedef logic [SCORE_W-1:0] score_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_CINIT,
		ST_CRUN,
		ST_CDRAIN,
		ST_TPOP,
		ST_TPOPW,
		ST_TCHK,
		ST_TSPW,
		ST_TEMIT,
		ST_TFIN
	} state_t;

endpackage

/* hw/rtl/rnabpm_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnabpm_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module rnabpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/rna_base_pair_maximizer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rna_base_pair_maximizer_unit
// Nussinov base-pair maximizer with traceback over an interval stack.
// ----------------------------------------------------------------------------
// usage:
//   bases enter on s_* one item per cycle while loading (s_tdata[1:0] = base,
//   s_tlast marks the final base). bases beyond 128 are dropped and flagged.
//   after the final base the block fills the score/split tables held in two
//   16k-entry RAMs, one split point t per cycle. traceback then walks the
//   tables, and pairs leave on m_* in preorder, one item each; the last
//   item of a run carries m_tlast.
//   with no pair, one item with pair_valid 0 is sent.
//   s_tready is high only while loading; the next run may start while the
//   final result still waits in the output register.
//   a stalled receiver holds m_* and stalls the traceback, nothing is lost.
//   cfg_* writes min_pair_distance (0 acts as 1); always ready, write it
//   only while idle. reset clears counters and control; the tables need no
//   clearing since cells shorter than the distance read as empty.
// ----------------------------------------------------------------------------
module rna_base_pair_maximizer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [1:0] base
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] left_pos, [15:8] right_pos
	output logic [1:0]  m_tuser,   // [0] pair_valid, [1] too_long
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data
);

	import rnabpm_pkg::*;

	localparam int TAB_AW = 2 * IDX_W;

	state_t state_q, state_d;

	logic [DIST_W-1:0] cfg_q;
	logic [DIST_W-1:0] pair_dist;
	pos_t cnt_q, n_new;
	logic ovf_q;
	logic s_acc, last_acc;

	pos_t i_q, k_q, t_q, j, t_s1;
	logic [1:0] seqj_q;
	logic loadj_q;
	logic vld_s1, skip_s1, za_s1, zb_s1;
	score_t best_q, sa, sb, val, score_fin;
	logic [SPLIT_W-1:0] choice_q, choice_fin, s_split;
	logic pair_hit, upd;

	pos_t l_q, r_q;
	logic [SP_W-1:0] sp_q;
	logic pend_v_q;
	pos_t pend_l_q, pend_r_q, new_l_q, new_r_q;
	logic tchk_break, push_en, out_free;
	logic last_cell, diag_done;

	logic m_tvalid_q, out_pv_q, out_ovf_q, out_last_q;
	pos_t out_l_q, out_r_q;

	logic               seq_we;
	logic [IDX_W-1:0]   seq_raddr;
	logic [1:0]         seq_rdata;
	logic               tab_we;
	logic [TAB_AW-1:0]  tab_waddr, a_raddr, b_raddr;
	logic [SPLIT_W+SCORE_W-1:0] a_rdata;
	score_t             b_rdata;
	logic [2*POS_W-1:0] stk_rdata;

	assign pair_dist = (cfg_q == '0) ? DIST_W'(1) : cfg_q;
	assign s_tready = (state_q == ST_LOAD);
	assign s_acc    = s_tvalid && s_tready;
	assign last_acc = s_acc && s_tlast;
	assign n_new    = (cnt_q < POS_W'(MAX_BASES)) ? cnt_q + POS_W'(1) : cnt_q;
	assign cfg_ready = 1'b1;
	assign j        = i_q + k_q;
	assign out_free = !m_tvalid_q || m_tready;

	// fill datapath
	assign sa  = za_s1 ? '0 : a_rdata[SCORE_W-1:0];
	assign sb  = zb_s1 ? '0 : b_rdata;
	assign val = score_t'(SCORE_W'(1) + sa + sb);
	assign pair_hit = vld_s1 && !skip_s1 && ((seq_rdata ^ seqj_q) == 2'b11);
	assign upd = pair_hit && (val > best_q);
	assign score_fin  = (sa > best_q) ? sa : best_q;
	assign choice_fin = (sa > best_q) ? SPLIT_SKIP : choice_q;
	assign last_cell  = ({1'b0, i_q} + 9'd1 + {1'b0, k_q}) > {1'b0, cnt_q};
	assign diag_done  = ({1'b0, k_q} + 9'd1) >= {1'b0, cnt_q};

	// traceback datapath
	assign s_split    = a_rdata[SPLIT_W+SCORE_W-1:SCORE_W];
	assign tchk_break = (l_q == '0) || (l_q > r_q) ||
	                    ((r_q - l_q) < POS_W'(pair_dist));
	assign push_en    = ({1'b0, s_split} + 9'd2) <= {1'b0, r_q};

	assign seq_we    = s_acc && (cnt_q < POS_W'(MAX_BASES));
	assign seq_raddr = (state_q == ST_CINIT) ? IDX_W'(j - POS_W'(1))
	                                         : IDX_W'(t_q - POS_W'(1));
	assign tab_we    = (state_q == ST_CDRAIN);
	assign tab_waddr = {IDX_W'(i_q - POS_W'(1)), IDX_W'(j - POS_W'(1))};
	assign a_raddr   = (state_q == ST_TCHK) ?
	                   {IDX_W'(l_q - POS_W'(1)), IDX_W'(r_q - POS_W'(1))} :
	                   {IDX_W'(i_q - POS_W'(1)), IDX_W'(t_q - POS_W'(2))};
	assign b_raddr   = {IDX_W'(t_q), IDX_W'(j - POS_W'(2))};

	rnabpm_ram #(.WIDTH(2), .DEPTH(MAX_BASES)) u_seq_ram (
		.clk   (clk),
		.we    (seq_we),
		.waddr (IDX_W'(cnt_q)),
		.wdata (s_tdata[1:0]),
		.raddr (seq_raddr),
		.rdata (seq_rdata)
	);

	rnabpm_ram #(.WIDTH(SPLIT_W + SCORE_W), .DEPTH(TAB_DEPTH)) u_tab_a_ram (
		.clk   (clk),
		.we    (tab_we),
		.waddr (tab_waddr),
		.wdata ({choice_fin, score_fin}),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	rnabpm_ram #(.WIDTH(SCORE_W), .DEPTH(TAB_DEPTH)) u_tab_b_ram (
		.clk   (clk),
		.we    (tab_we),
		.waddr (tab_waddr),
		.wdata (score_fin),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	rnabpm_ram #(.WIDTH(2 * POS_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
		.clk   (clk),
		.we    ((state_q == ST_TSPW) && (s_split != SPLIT_NONE) &&
		        (s_split != SPLIT_SKIP) && push_en),
		.waddr (sp_q[SP_W-2:0]),
		.wdata ({r_q - POS_W'(1), s_split + POS_W'(1)}),
		.raddr (sp_q[SP_W-2:0] - (SP_W-1)'(1)),
		.rdata (stk_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (last_acc) begin
					state_d = (POS_W'(pair_dist) >= n_new) ? ST_TCHK : ST_CINIT;
				end
			end
			ST_CINIT:  state_d = ST_CRUN;
			ST_CRUN: begin
				if (t_q == j) begin
					state_d = ST_CDRAIN;
				end
			end
			ST_CDRAIN: begin
				state_d = (last_cell && diag_done) ? ST_TCHK : ST_CINIT;
			end
			ST_TPOP:   state_d = ST_TPOPW;
			ST_TPOPW:  state_d = ST_TCHK;
			ST_TCHK: begin
				if (tchk_break) begin
					state_d = (sp_q == '0) ? ST_TFIN : ST_TPOP;
				end else begin
					state_d = ST_TSPW;
				end
			end
			ST_TSPW: begin
				if (s_split == SPLIT_NONE) begin
					state_d = (sp_q == '0) ? ST_TFIN : ST_TPOP;
				end else if (s_split == SPLIT_SKIP) begin
					state_d = ST_TCHK;
				end else begin
					state_d = pend_v_q ? ST_TEMIT : ST_TCHK;
				end
			end
			ST_TEMIT: begin
				if (out_free) begin
					state_d = ST_TCHK;
				end
			end
			ST_TFIN: begin
				if (out_free) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q      <= DIST_W'(5);
			cnt_q      <= '0;
			ovf_q      <= 1'b0;
			vld_s1     <= 1'b0;
			loadj_q    <= 1'b0;
			sp_q       <= '0;
			pend_v_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				cfg_q <= cfg_data;
			end
			if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			vld_s1 <= 1'b0;
			case (state_q)
				ST_LOAD: begin
					if (s_acc) begin
						cnt_q <= n_new;
						if (cnt_q >= POS_W'(MAX_BASES)) begin
							ovf_q <= 1'b1;
						end
					end
					if (last_acc) begin
						i_q  <= POS_W'(1);
						k_q  <= POS_W'(pair_dist);
						l_q  <= POS_W'(1);
						r_q  <= n_new;
						sp_q <= '0;
					end
				end
				ST_CINIT: begin
					t_q      <= i_q;
					best_q   <= '0;
					choice_q <= SPLIT_NONE;
					loadj_q  <= 1'b1;
				end
				ST_CRUN: begin
					if (loadj_q) begin
						seqj_q  <= seq_rdata;
						loadj_q <= 1'b0;
					end
					vld_s1  <= 1'b1;
					t_s1    <= t_q;
					skip_s1 <= (t_q == j);
					za_s1   <= {1'b0, t_q} < ({1'b0, i_q} + 9'(pair_dist) + 9'd1);
					zb_s1   <= {1'b0, j} < ({1'b0, t_q} + 9'(pair_dist) + 9'd2);
					t_q     <= (t_q == j - POS_W'(pair_dist)) ? j : t_q + POS_W'(1);
					if (upd) begin
						best_q   <= val;
						choice_q <= t_s1;
					end
				end
				ST_CDRAIN: begin
					if (last_cell) begin
						i_q <= POS_W'(1);
						k_q <= k_q + POS_W'(1);
					end else begin
						i_q <= i_q + POS_W'(1);
					end
					l_q  <= POS_W'(1);
					r_q  <= cnt_q;
					sp_q <= '0;
				end
				ST_TPOP: begin
					sp_q <= sp_q - SP_W'(1);
				end
				ST_TPOPW: begin
					l_q <= stk_rdata[POS_W-1:0];
					r_q <= stk_rdata[2*POS_W-1:POS_W];
				end
				ST_TSPW: begin
					if (s_split == SPLIT_SKIP) begin
						r_q <= r_q - POS_W'(1);
					end else if (s_split != SPLIT_NONE) begin
						if (push_en) begin
							sp_q <= sp_q + SP_W'(1);
						end
						r_q <= s_split - POS_W'(1);
						if (pend_v_q) begin
							new_l_q <= s_split;
							new_r_q <= r_q;
						end else begin
							pend_v_q <= 1'b1;
							pend_l_q <= s_split;
							pend_r_q <= r_q;
						end
					end
				end
				ST_TEMIT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						out_pv_q   <= 1'b1;
						out_l_q    <= pend_l_q;
						out_r_q    <= pend_r_q;
						out_ovf_q  <= ovf_q;
						out_last_q <= 1'b0;
						pend_l_q   <= new_l_q;
						pend_r_q   <= new_r_q;
					end
				end
				ST_TFIN: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						out_pv_q   <= pend_v_q;
						out_l_q    <= pend_v_q ? pend_l_q : '0;
						out_r_q    <= pend_v_q ? pend_r_q : '0;
						out_ovf_q  <= ovf_q;
						out_last_q <= 1'b1;
						pend_v_q   <= 1'b0;
						cnt_q      <= '0;
						ovf_q      <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_r_q, out_l_q};
	assign m_tuser  = {out_ovf_q, out_pv_q};
	assign m_tlast  = out_last_q;

	// a reported pair always has its left base before its right base
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[7:0] < m_tdata[15:8])
		else $error("pair with left position not below right position");

	// the interval stack never holds more entries than there can be pairs
	a_stack_depth: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STACK_DEPTH))
		else $error("interval stack overflow");

	// the split point sweep never runs past the left or the right end of the cell
	a_split_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CRUN |-> t_q <= j && t_q >= i_q)
		else $error("split point outside cell");

	// a result waiting for the receiver stays until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result dropped while stalled");

endmodule

/* sim/rna_base_pair_maximizer_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rna_base_pair_maximizer_unit_tb
// Drives RNA sequences into the base-pair maximizer, folds each one in a
// behavioral Nussinov predictor and checks every emitted pair, in order,
// against it. Covers distance settings, overflow and output back-pressure.
// ----------------------------------------------------------------------------
module rna_base_pair_maximizer_unit_tb;
	import rnabpm_pkg::*;

	localparam int DIMN = MAX_BASES + 2;
	localparam int MAX_PAIRS = MAX_BASES / 2;

	typedef struct {
		bit   pair_valid;
		pos_t left_pos;
		pos_t right_pos;
		bit   too_long;
		bit   last_result;
	} pair_item_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tlast = 0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [4:0]  cfg_data = '0;

	pair_item_t pairs_expected[$];
	int         errors = 0;
	int         ready_pct = 70;
	int         long_hold_req = 0;
	int         stall_left = 0;
	bit         no_gaps = 0;

	// folding state of the predictor
	bit [1:0]       seq_mem [1:MAX_BASES];
	int             seq_len = 0;
	bit             seq_over = 0;
	int             min_dist = 5;
	int             fold_score [0:DIMN-1][0:DIMN-1];
	logic [7:0]     fold_split [0:DIMN-1][0:DIMN-1];

	rna_base_pair_maximizer_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	initial begin
		#50_000_000;
		$display("Some tests failed");
		$finish;
	end

	function automatic int score_of(int a, int b);
		if (a > b || a >= DIMN || b >= DIMN) return 0;
		return fold_score[a][b];
	endfunction

	task automatic fold_sequence();
		int n, d, j, best, val, cnt, l, r, s;
		logic [7:0] ch;
		int stk_l[$], stk_r[$];
		pair_item_t found[$];
		pair_item_t p;
		n = seq_len;
		d = (min_dist == 0) ? 1 : min_dist;
		for (int a = 0; a < DIMN; a++)
			for (int b = 0; b < DIMN; b++) begin
				fold_score[a][b] = 0;
				fold_split[a][b] = SPLIT_NONE;
			end
		for (int k = d; k < n; k++)
			for (int i = 1; i + k <= n; i++) begin
				j = i + k;
				best = 0;
				ch = SPLIT_NONE;
				for (int t = i; t + d <= j; t++)
					if (int'(seq_mem[t]) + int'(seq_mem[j]) == 3) begin
						val = 1 + score_of(i, t - 1) + score_of(t + 1, j - 1);
						if (val > best) begin
							best = val;
							ch = t[7:0];
						end
					end
				if (score_of(i, j - 1) > best) begin
					best = score_of(i, j - 1);
					ch = SPLIT_SKIP;
				end
				fold_score[i][j] = best;
				fold_split[i][j] = ch;
			end
		cnt = 0;
		stk_l.push_back(1);
		stk_r.push_back(n);
		while (stk_l.size() > 0) begin
			l = stk_l.pop_back();
			r = stk_r.pop_back();
			while (l >= 1 && l <= r && r < DIMN) begin
				if (fold_split[l][r] == SPLIT_NONE) break;
				if (fold_split[l][r] == SPLIT_SKIP) begin
					r--;
					continue;
				end
				s = fold_split[l][r];
				if (cnt < MAX_PAIRS) begin
					p = '{1'b1, pos_t'(s), pos_t'(r), seq_over, 1'b0};
					found.push_back(p);
					cnt++;
				end
				if (s + 1 <= r - 1) begin
					stk_l.push_back(s + 1);
					stk_r.push_back(r - 1);
				end
				r = s - 1;
			end
		end
		if (found.size() == 0) begin
			p = '{1'b0, pos_t'(0), pos_t'(0), seq_over, 1'b0};
			found.push_back(p);
		end
		found[found.size() - 1].last_result = 1'b1;
		foreach (found[q]) pairs_expected.push_back(found[q]);
		seq_len = 0;
		seq_over = 0;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_base(bit [1:0] b, bit last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, b};
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		if (seq_len < MAX_BASES) begin
			seq_len++;
			seq_mem[seq_len] = b;
		end else begin
			seq_over = 1;
		end
		if (last) fold_sequence();
	endtask

	task automatic send_sequence(bit [1:0] q[$]);
		foreach (q[k]) send_base(q[k], k == q.size() - 1);
	endtask

	task automatic send_random_sequence(int len);
		bit [1:0] q[$];
		repeat (len) q.push_back(2'($urandom_range(0, 3)));
		send_sequence(q);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pairs_expected.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_distance(logic [4:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		min_dist = v;
	endtask

	// output side: random ready, occasional long stalls, requested hold-off
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pairs_expected.size() == 0) begin
					$error("unexpected item left=%0d right=%0d", m_tdata[7:0], m_tdata[15:8]);
					errors++;
				end else begin
					pair_item_t e;
					e = pairs_expected.pop_front();
					if (m_tuser[0] !== e.pair_valid) begin
						$error("pair_valid exp %0d got %0d", e.pair_valid, m_tuser[0]);
						errors++;
					end
					if (m_tdata[7:0] !== e.left_pos) begin
						$error("left_pos exp %0d got %0d", e.left_pos, m_tdata[7:0]);
						errors++;
					end
					if (m_tdata[15:8] !== e.right_pos) begin
						$error("right_pos exp %0d got %0d", e.right_pos, m_tdata[15:8]);
						errors++;
					end
					if (m_tuser[1] !== e.too_long) begin
						$error("too_long exp %0d got %0d", e.too_long, m_tuser[1]);
						errors++;
					end
					if (m_tlast !== e.last_result) begin
						$error("last_result exp %0d got %0d", e.last_result, m_tlast);
						errors++;
					end
				end
			end
			if (long_hold_req > 0) begin
				stall_left = long_hold_req;
				long_hold_req = 0;
			end else if (stall_left == 0 && ready_pct < 100 && $urandom_range(0, 199) == 0) begin
				stall_left = $urandom_range(20, 120);
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) < ready_pct);
			end
		end
	end

	task automatic test_directed();
		send_sequence('{2'd2, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd1});
		send_sequence('{2'd3});
		wait_idle();
		write_distance(5'd1);
		send_sequence('{2'd0, 2'd3, 2'd1, 2'd2, 2'd2, 2'd1});
		wait_idle();
		write_distance(5'd16);
		send_sequence('{2'd1, 2'd1, 2'd0, 2'd3, 2'd2, 2'd2});
		wait_idle();
	endtask

	task automatic test_distances();
		logic [4:0] dists[$];
		dists = '{5'd0, 5'd1, 5'd3, 5'd16, 5'd31, 5'($urandom_range(2, 15))};
		foreach (dists[k]) begin
			write_distance(dists[k]);
			send_random_sequence($urandom_range(2, 12));
			wait_idle();
		end
	endtask

	task automatic test_overflow();
		write_distance(5'd1);
		send_random_sequence(MAX_BASES + 2);
		send_random_sequence(3);
		wait_idle();
	endtask

	task automatic test_backpressure();
		write_distance(5'd1);
		no_gaps = 1;
		ready_pct = 100;
		send_random_sequence(6);
		wait_idle();
		long_hold_req = 6000;
		send_sequence('{2'd1, 2'd1, 2'd1, 2'd0, 2'd0, 2'd3, 2'd3, 2'd2, 2'd2, 2'd2});
		send_random_sequence(8);
		no_gaps = 0;
		ready_pct = 70;
		send_random_sequence(6);
		wait_idle();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_distances();
		test_overflow();
		test_backpressure();
		wait_idle();
		repeat (100) @(posedge clk);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/rnabpm_pkg.sv
hw/rtl/rnabpm_ram.sv
hw/rtl/rna_base_pair_maximizer_unit.sv
sim/rna_base_pair_maximizer_unit_tb.sv
